[sv/gpc_pkg.sv]
// ----------------------------------------------------------------------------
// gpc_pkg
// shared types and constants of the grid path counter
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 128;
  localparam int QUEUE_DEPTH     = 2;

  localparam int COUNT_W   = 30;
  localparam int SIZE_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] PATH_PRIME = 30'd1000000007;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 2'd0,
    CFG_GRID_ROWS    = 2'd1
  } cfg_reg_t;

  // classification of one cell, handed from front to back
  typedef struct packed {
    logic blocked;
    logic home;
    logic top_row;
    logic first_col;
    logic final_cell;
  } cell_flags_t;

  localparam int FLAGS_W = $bits(cell_flags_t);

endpackage

[sv/gpc_cell_if.sv]
// ----------------------------------------------------------------------------
// gpc_cell_if
// cell channel: one grid cell per request with its blocked flag
// ----------------------------------------------------------------------------
interface gpc_cell_if;
  logic valid;
  logic ready;
  logic blocked;

  modport source (output valid, output blocked, input ready);
  modport sink (input valid, input blocked, output ready);
endinterface

[sv/gpc_count_if.sv]
// ----------------------------------------------------------------------------
// gpc_count_if
// result channel: path count of one cell and the final cell mark
// ----------------------------------------------------------------------------
interface gpc_count_if import gpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] path_count;
  logic               final_cell;

  modport source (output valid, output path_count, output final_cell, input ready);
  modport sink (input valid, input path_count, input final_cell, output ready);
endinterface

[sv/gpc_cfg_if.sv]
// ----------------------------------------------------------------------------
// gpc_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface gpc_cfg_if import gpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/gpc_front.sv]
// ----------------------------------------------------------------------------
// gpc_front
// grid size registers, raster position counters and cell classification
// ----------------------------------------------------------------------------
module gpc_front import gpc_pkg::*; #(
  parameter int  MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int  MAX_ROWS    = DEF_MAX_ROWS,
  localparam int COL_W       = $clog2(MAX_COLUMNS),
  localparam int ROW_W       = $clog2(MAX_ROWS)
) (
  input  logic             clk,
  input  logic             rst,
  gpc_cell_if.sink         cells,
  gpc_cfg_if.sink          cfg,
  output logic             push_valid,
  input  logic             push_ready,
  output cell_flags_t      push_flags,
  output logic [COL_W-1:0] push_col
);

  localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);

  logic [COLS_W-1:0] grid_columns;
  logic [ROWS_W-1:0] grid_rows;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_next;
  logic [COLS_W-1:0] cfg_cols;
  logic [ROWS_W-1:0] cfg_rows;
  logic              last_col;
  logic              last_row;
  logic              accept;
  logic              cfg_write;

  assign cfg.ready   = 1'b1;
  assign cfg_write   = cfg.valid;
  assign cells.ready = push_ready;
  assign push_valid  = cells.valid;
  assign accept      = cells.valid && push_ready;

  // zero reads as one, oversize saturates
  always_comb begin
    if (cfg.data == '0) begin
      cfg_cols = COLS_W'(1);
      cfg_rows = ROWS_W'(1);
    end else begin
      if (32'(cfg.data) > 32'(MAX_COLUMNS)) begin
        cfg_cols = COLS_W'(MAX_COLUMNS);
      end else begin
        cfg_cols = COLS_W'(cfg.data);
      end
      if (32'(cfg.data) > 32'(MAX_ROWS)) begin
        cfg_rows = ROWS_W'(MAX_ROWS);
      end else begin
        cfg_rows = ROWS_W'(cfg.data);
      end
    end
  end

  always_comb begin
    last_col = (COLS_W'(col) + COLS_W'(1)) == grid_columns;
    last_row = (ROWS_W'(row) + ROWS_W'(1)) == grid_rows;
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row + ROW_W'(1);
    end else begin
      col_next = col + COL_W'(1);
      row_next = row;
    end
    push_flags.blocked    = cells.blocked;
    push_flags.home       = (col == '0) && (row == '0);
    push_flags.top_row    = (row == '0);
    push_flags.first_col  = (col == '0);
    push_flags.final_cell = last_col && last_row;
    push_col              = col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= COLS_W'(1);
      grid_rows    <= ROWS_W'(1);
      col          <= '0;
      row          <= '0;
    end else if (cfg_write) begin
      unique case (cfg.index)
        CFG_GRID_COLUMNS: begin
          grid_columns <= cfg_cols;
          col          <= '0;
          row          <= '0;
        end
        CFG_GRID_ROWS: begin
          grid_rows <= cfg_rows;
          col       <= '0;
          row       <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

[sv/gpc_queue.sv]
// ----------------------------------------------------------------------------
// gpc_queue
// small first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module gpc_queue import gpc_pkg::*; #(
  parameter int WIDTH = FLAGS_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign in_ready  = fill != CNT_W'(DEPTH);
  assign out_valid = fill != '0;
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

[sv/gpc_back.sv]
// ----------------------------------------------------------------------------
// gpc_back
// line buffer, modular path sum and output register
// ----------------------------------------------------------------------------
module gpc_back import gpc_pkg::*; #(
  parameter int  MAX_COLUMNS = DEF_MAX_COLUMNS,
  localparam int COL_W       = $clog2(MAX_COLUMNS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  cell_flags_t      pop_flags,
  input  logic [COL_W-1:0] pop_col,
  gpc_count_if.source      counts
);

  logic [COUNT_W-1:0] line_buf [MAX_COLUMNS];
  logic [COUNT_W-1:0] above_rd;
  logic               a_valid;
  cell_flags_t        a_flags;
  logic [COL_W-1:0]   a_col;
  logic               bypass;
  logic [COUNT_W-1:0] left_count;
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  logic               out_final;
  logic [COUNT_W-1:0] above;
  logic [COUNT_W-1:0] left;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W:0]   sum_red;
  logic [COUNT_W-1:0] count;
  logic               advance;
  logic               pop;

  assign advance   = a_valid && (!out_valid || counts.ready);
  assign pop_ready = !a_valid || advance;
  assign pop       = pop_valid && pop_ready;

  assign counts.valid      = out_valid;
  assign counts.path_count = out_count;
  assign counts.final_cell = out_final;

  always_comb begin
    // single-column grid: the cell above is the previous cell, not yet in the buffer
    if (a_flags.top_row) begin
      above = '0;
    end else if (bypass) begin
      above = left_count;
    end else begin
      above = above_rd;
    end
    left    = a_flags.first_col ? '0 : left_count;
    sum     = {1'b0, above} + {1'b0, left};
    sum_red = sum - {1'b0, PATH_PRIME};
    if (a_flags.blocked) begin
      count = '0;
    end else if (a_flags.home) begin
      count = COUNT_W'(1);
    end else if (sum >= {1'b0, PATH_PRIME}) begin
      count = sum_red[COUNT_W-1:0];
    end else begin
      count = sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_buf[a_col] <= count;
    end
    if (pop) begin
      above_rd <= line_buf[pop_col];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_flags <= pop_flags;
      a_col   <= pop_col;
      bypass  <= advance && (a_col == pop_col);
    end
    if (advance) begin
      out_count <= count;
      out_final <= a_flags.final_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      out_valid  <= 1'b0;
      left_count <= '0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (advance) begin
        out_valid  <= 1'b1;
        left_count <= count;
      end else if (counts.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/grid_path_counter_mod_prime.sv]
// ----------------------------------------------------------------------------
// grid_path_counter_mod_prime
// right-and-down path counts over a grid with blocked cells, modulo the prime
// path: a cell goes through the queue, the back end stage and the output register
// throughput: one cell per cycle if no stall, set by add/reduce loop on left_count
// line buffer: one write and one registered read per cycle
// reset: grid is 1 by 1, position at home cell, line buffer left uncleared
// ----------------------------------------------------------------------------
module grid_path_counter_mod_prime import gpc_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  gpc_cell_if.sink    cells,
  gpc_count_if.source counts,
  gpc_cfg_if.sink     cfg
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int Q_W   = FLAGS_W + COL_W;

  logic             q_in_valid;
  logic             q_in_ready;
  cell_flags_t      q_in_flags;
  logic [COL_W-1:0] q_in_col;
  logic             q_out_valid;
  logic             q_out_ready;
  logic [Q_W-1:0]   q_out_data;
  cell_flags_t      q_out_flags;
  logic [COL_W-1:0] q_out_col;

  assign q_out_flags = cell_flags_t'(q_out_data[Q_W-1:COL_W]);
  assign q_out_col   = q_out_data[COL_W-1:0];

  gpc_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cells      (cells),
    .cfg        (cfg),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_flags (q_in_flags),
    .push_col   (q_in_col)
  );

  gpc_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_data   ({q_in_flags, q_in_col}),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_data  (q_out_data)
  );

  gpc_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_out_valid),
    .pop_ready (q_out_ready),
    .pop_flags (q_out_flags),
    .pop_col   (q_out_col),
    .counts    (counts)
  );

  a_count_reduced: assert property (@(posedge clk) disable iff (rst)
    counts.valid |-> (counts.path_count < PATH_PRIME))
    else $error("path count not reduced below the prime");

  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    (q_out_valid && !q_out_ready) |=> (q_out_valid && $stable(q_out_data)))
    else $error("queue head lost while back end stalled");

endmodule

[verif/grid_path_counter_mod_prime_tb.sv]
// ----------------------------------------------------------------------------
// grid_path_counter_mod_prime_tb
// Feeds grids of blocked and free cells in raster order through the cell
// channel and sets the grid size through the configuration channel. An
// in-bench path count predictor works out each cell's count and final mark,
// and every count request is compared against the oldest prediction. The run
// covers directed corner grids, then random grids of many sizes under varying
// sender and receiver idling, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module grid_path_counter_mod_prime_tb;
  import gpc_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] path_count;
    logic               final_cell;
  } cell_count_t;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

  logic clk;
  logic rst;

  gpc_cell_if  cell_ch ();
  gpc_count_if count_ch ();
  gpc_cfg_if   cfg_ch ();

  grid_path_counter_mod_prime uut (
    .clk    (clk),
    .rst    (rst),
    .cells  (cell_ch),
    .counts (count_ch),
    .cfg    (cfg_ch)
  );

  logic               cell_backlog[$];
  cell_count_t        count_expect[$];
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic [COUNT_W-1:0] row_above[DEF_MAX_COLUMNS];
  logic [COUNT_W-1:0] left_path;
  int                 col_pos;
  int                 row_pos;
  int                 mismatches = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  logic               hold_active = 1'b0;
  logic               hold_request = 1'b0;
  logic               hold_done = 1'b0;

  function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [SIZE_W-1:0] val);
    if (idx == CFG_GRID_COLUMNS) begin
      width_reg = val;
    end else if (idx == CFG_GRID_ROWS) begin
      height_reg = val;
    end else begin
      return;
    end
    left_path = '0;
    col_pos   = 0;
    row_pos   = 0;
  endfunction

  function automatic void predict_path_count(input logic blk);
    int                 cols;
    int                 rows;
    int                 c;
    int                 r;
    logic [COUNT_W-1:0] up;
    logic [COUNT_W-1:0] lf;
    logic [COUNT_W:0]   sum;
    cell_count_t        res;
    cols = clamp_size(width_reg, DEF_MAX_COLUMNS);
    rows = clamp_size(height_reg, DEF_MAX_ROWS);
    c = (col_pos >= cols) ? cols - 1 : col_pos;
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    up = (r > 0) ? row_above[c] : '0;
    lf = (c > 0) ? left_path : '0;
    if (blk) begin
      sum = '0;
    end else if (r == 0 && c == 0) begin
      sum = (COUNT_W+1)'(1);
    end else begin
      sum = {1'b0, up} + {1'b0, lf};
      if (sum >= {1'b0, PATH_PRIME}) sum = sum - {1'b0, PATH_PRIME};
    end
    row_above[c] = sum[COUNT_W-1:0];
    left_path    = sum[COUNT_W-1:0];
    res.path_count = sum[COUNT_W-1:0];
    res.final_cell = (c + 1 >= cols) && (r + 1 >= rows);
    count_expect.push_back(res);
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cell driver
  always @(posedge clk) begin
    if (rst) begin
      cell_ch.valid   <= 1'b0;
      cell_ch.blocked <= 1'b0;
    end else if (!cell_ch.valid || cell_ch.ready) begin
      if (cell_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cell_ch.valid   <= 1'b1;
        cell_ch.blocked <= cell_backlog.pop_front();
      end else begin
        cell_ch.valid <= 1'b0;
      end
    end
  end

  // count receiver
  always @(posedge clk) begin
    if (rst) begin
      count_ch.ready <= 1'b0;
    end else begin
      count_ch.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, counted in cycles
  initial begin : receiver_hold
    wait (hold_request);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (300) @(posedge clk);
    hold_active <= 1'b0;
    hold_done   <= 1'b1;
  end

  // monitor: register writes, cell requests and count requests
  always @(posedge clk) begin : count_monitor
    cell_count_t want;
    if (rst) begin
      width_reg  = SIZE_W'(1);
      height_reg = SIZE_W'(1);
      left_path  = '0;
      col_pos    = 0;
      row_pos    = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg_write(cfg_ch.index, cfg_ch.data);
      if (cell_ch.valid && cell_ch.ready) predict_path_count(cell_ch.blocked);
      if (count_ch.valid && count_ch.ready) begin
        if (count_expect.size() == 0) begin
          mismatches++;
          $display("%0t: count request with none expected, actual count %0d final %0b",
                   $time, count_ch.path_count, count_ch.final_cell);
        end else begin
          want = count_expect.pop_front();
          if (count_ch.path_count !== want.path_count) begin
            mismatches++;
            $display("%0t: path_count expected %0d actual %0d",
                     $time, want.path_count, count_ch.path_count);
          end
          if (count_ch.final_cell !== want.final_cell) begin
            mismatches++;
            $display("%0t: final_cell expected %0b actual %0b",
                     $time, want.final_cell, count_ch.final_cell);
          end
        end
      end
    end
  end

  // sampled at the falling edge, clear of the driver and monitor updates
  task automatic wait_drained();
    @(negedge clk);
    while (cell_backlog.size() != 0 || cell_ch.valid || count_expect.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    wait_drained();
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_rates(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic push_pattern(input logic [15:0] pat, input int n);
    for (int i = 0; i < n; i++) cell_backlog.push_back(pat[i]);
  endtask

  task automatic push_random(input int n, input int block_pct);
    for (int i = 0; i < n; i++) cell_backlog.push_back($urandom_range(99) < block_pct);
  endtask

  task automatic random_grids(input int n_cells, input int max_dim, input int block_pct);
    int sent;
    int w;
    int h;
    int cells;
    sent = 0;
    while (sent < n_cells) begin
      w = $urandom_range(max_dim, 1);
      h = $urandom_range(max_dim, 1);
      if ($urandom_range(9) == 0) w = 0;
      if ($urandom_range(9) == 0) h = 0;
      write_reg(CFG_GRID_COLUMNS, SIZE_W'(w));
      write_reg(CFG_GRID_ROWS, SIZE_W'(h));
      cells = clamp_size(SIZE_W'(w), DEF_MAX_COLUMNS) * clamp_size(SIZE_W'(h), DEF_MAX_ROWS);
      case ($urandom_range(3))
        0: cells = $urandom_range(cells, 1);
        1: cells = cells * 2;
        default: ;
      endcase
      push_random(cells, block_pct);
      sent += cells;
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_GRID_COLUMNS;
    cfg_ch.data    = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one by one grid after reset: free home, then blocked home
    push_pattern(16'b10, 2);
    write_reg(CFG_GRID_COLUMNS, 8'd3);
    write_reg(CFG_GRID_ROWS, 8'd3);
    push_pattern(16'b000_010_000, 9);
    // restart part way through a grid
    push_pattern(16'b00, 2);
    write_reg(CFG_GRID_ROWS, 8'd2);
    push_pattern(16'b001_000, 6);
    // spare index must leave the traversal alone
    push_pattern(16'b01, 2);
    write_reg(CFG_SPARE, 8'hAA);
    push_pattern(16'b0, 1);
    // zero and oversized values
    write_reg(CFG_GRID_COLUMNS, 8'h00);
    write_reg(CFG_GRID_ROWS, 8'hFF);
    push_pattern(16'b000, 3);

    // large open grid so counts wrap round the prime
    write_reg(CFG_GRID_COLUMNS, 8'd19);
    write_reg(CFG_GRID_ROWS, 8'd19);
    push_random(361, 1);

    set_rates(84, 0);
    random_grids(100, 8, 25);

    set_rates(0, 84);
    write_reg(CFG_GRID_COLUMNS, SIZE_W'(DEF_MAX_COLUMNS));
    write_reg(CFG_GRID_ROWS, 8'd2);
    push_random(2 * DEF_MAX_COLUMNS, 3);
    write_reg(CFG_GRID_COLUMNS, 8'd1);
    write_reg(CFG_GRID_ROWS, SIZE_W'(DEF_MAX_ROWS));
    push_random(DEF_MAX_ROWS, 3);

    // long receiver hold-off while cells keep coming
    set_rates(0, 31);
    write_reg(CFG_GRID_COLUMNS, 8'd8);
    write_reg(CFG_GRID_ROWS, 8'd8);
    push_random(64, 20);
    hold_request <= 1'b1;
    wait (hold_done);

    set_rates(31, 31);
    random_grids(100, 12, 15);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && count_expect.size() == 0) begin
      $display("PASS grid_path_counter_mod_prime");
    end else begin
      $display("FAIL grid_path_counter_mod_prime");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL grid_path_counter_mod_prime");
    $finish;
  end

endmodule

[files.f]
sv/gpc_pkg.sv
sv/gpc_cell_if.sv
sv/gpc_count_if.sv
sv/gpc_cfg_if.sv
sv/gpc_front.sv
sv/gpc_queue.sv
sv/gpc_back.sv
sv/grid_path_counter_mod_prime.sv
verif/grid_path_counter_mod_prime_tb.sv
